// ----- sv/mlcs_pkg.sv -----
`default_nettype none

package mlcs_pkg;

  localparam int unsigned WIDTH  = 32;
  localparam int unsigned TW     = WIDTH + 2;
  localparam int unsigned PW     = WIDTH + 3;
  localparam int unsigned CNT_W  = $clog2(WIDTH);
  localparam int unsigned IN_W   = 3 * WIDTH;

  typedef enum logic [1:0] {
    STAT_SOLVED   = 2'd0,
    STAT_NO_SOL   = 2'd1,
    STAT_ZERO_MOD = 2'd2
  } status_t;

  typedef struct packed {
    logic                    start;
    logic [WIDTH-1:0]        dividend;
    logic [WIDTH-1:0]        divisor;
    logic signed [TW-1:0]    mult;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic [WIDTH-1:0]        quot;
    logic [WIDTH-1:0]        rem;
    logic signed [PW-1:0]    prod;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- sv/modular_linear_congruence_solver_core.sv -----
`default_nettype none

// Solves a*x = b (mod n) for unsigned 32-bit a, b, n, one transaction at a time.
// Status 0 returns the least solution modulo n/gcd(a,n); status 1 means gcd(a,n)
// does not divide b; status 2 means n is zero. The solution is zero unless status
// is 0. All division work runs on one restoring divider that yields one quotient bit
// per cycle and also forms the Bezout update q*t1 on the fly. A solved item takes
// k+3 divisions and then a shift-and-add modular multiply, where k is the number
// of Euclid steps on (n, a mod n); an item stays in progress until its result is
// taken on out_tready. A zero modulus is answered without using the divider. The
// input is not ready while an item is in progress or its result waits on the output.
module modular_linear_congruence_solver_core (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [mlcs_pkg::IN_W-1:0] in_tdata,   // coeff_a, rhs_b, modulus_n
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [mlcs_pkg::WIDTH-1:0]     out_tdata,  // solution
  output logic [1:0]                     out_tuser   // status
);
  import mlcs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RED_GO, S_RED_W, S_EUC, S_EUC_W, S_B_GO, S_B_W,
    S_N_GO, S_N_W, S_FIX, S_FIX2, S_MUL, S_OUT
  } state_t;

  state_t               state_r, state_nxt;
  logic [WIDTH-1:0]     a_r, a_nxt;
  logic [WIDTH-1:0]     b_r, b_nxt;
  logic [WIDTH-1:0]     n_r, n_nxt;
  logic [WIDTH-1:0]     r0_r, r0_nxt;
  logic [WIDTH-1:0]     r1_r, r1_nxt;
  logic signed [TW-1:0] t0_r, t0_nxt;
  logic signed [TW-1:0] t1_r, t1_nxt;
  logic [WIDTH-1:0]     np_r, np_nxt;
  logic [WIDTH-1:0]     acc_r, acc_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  status_t              stat_r, stat_nxt;
  logic [WIDTH-1:0]     sol_r, sol_nxt;
  logic                 out_valid_r, out_valid_nxt;

  div_req_t             dreq;
  div_rsp_t             drsp;

  logic [WIDTH+1:0]     acc2;
  logic [WIDTH+1:0]     np1;
  logic [WIDTH+1:0]     np2;
  logic [WIDTH+1:0]     mul_pick;

  mlcs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  always_comb begin
    np1      = {2'b00, np_r};
    np2      = {1'b0, np_r, 1'b0};
    acc2     = {1'b0, acc_r, 1'b0} + (b_r[WIDTH-1] ? {2'b00, t0_r[WIDTH-1:0]} : '0);
    mul_pick = (acc2 >= np2) ? (acc2 - np2) : ((acc2 >= np1) ? (acc2 - np1) : acc2);
  end

  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    n_nxt         = n_r;
    r0_nxt        = r0_r;
    r1_nxt        = r1_r;
    t0_nxt        = t0_r;
    t1_nxt        = t1_r;
    np_nxt        = np_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    stat_nxt      = stat_r;
    sol_nxt       = sol_r;
    out_valid_nxt = out_valid_r;
    dreq          = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          a_nxt = in_tdata[WIDTH-1:0];
          b_nxt = in_tdata[2*WIDTH-1:WIDTH];
          n_nxt = in_tdata[3*WIDTH-1:2*WIDTH];
          if (in_tdata[3*WIDTH-1:2*WIDTH] == '0) begin
            stat_nxt      = STAT_ZERO_MOD;
            sol_nxt       = '0;
            out_valid_nxt = 1'b1;
            state_nxt     = S_OUT;
          end else begin
            state_nxt = S_RED_GO;
          end
        end
      end
      S_RED_GO: begin
        dreq.start    = 1'b1;
        dreq.dividend = a_r;
        dreq.divisor  = n_r;
        state_nxt     = S_RED_W;
      end
      S_RED_W: begin
        if (drsp.done) begin
          r0_nxt    = n_r;
          r1_nxt    = drsp.rem;
          t0_nxt    = '0;
          t1_nxt    = TW'(1);
          state_nxt = S_EUC;
        end
      end
      S_EUC: begin
        if (r1_r == '0) begin
          state_nxt = S_B_GO;
        end else begin
          dreq.start    = 1'b1;
          dreq.dividend = r0_r;
          dreq.divisor  = r1_r;
          dreq.mult     = t1_r;
          state_nxt     = S_EUC_W;
        end
      end
      S_EUC_W: begin
        if (drsp.done) begin
          r0_nxt    = r1_r;
          r1_nxt    = drsp.rem;
          t0_nxt    = t1_r;
          t1_nxt    = TW'(PW'(t0_r) - drsp.prod);
          state_nxt = S_EUC;
        end
      end
      S_B_GO: begin
        dreq.start    = 1'b1;
        dreq.dividend = b_r;
        dreq.divisor  = r0_r;
        state_nxt     = S_B_W;
      end
      S_B_W: begin
        if (drsp.done) begin
          if (drsp.rem != '0) begin
            stat_nxt      = STAT_NO_SOL;
            sol_nxt       = '0;
            out_valid_nxt = 1'b1;
            state_nxt     = S_OUT;
          end else begin
            b_nxt     = drsp.quot;
            state_nxt = S_N_GO;
          end
        end
      end
      S_N_GO: begin
        dreq.start    = 1'b1;
        dreq.dividend = n_r;
        dreq.divisor  = r0_r;
        state_nxt     = S_N_W;
      end
      S_N_W: begin
        if (drsp.done) begin
          np_nxt    = drsp.quot;
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        if (t0_r < 0) begin
          t0_nxt = t0_r + $signed(np1);
        end
        state_nxt = S_FIX2;
      end
      S_FIX2: begin
        if (t0_r >= $signed(np1)) begin
          t0_nxt = t0_r - $signed(np1);
        end
        acc_nxt   = '0;
        cnt_nxt   = CNT_W'(WIDTH - 1);
        state_nxt = S_MUL;
      end
      S_MUL: begin
        acc_nxt = mul_pick[WIDTH-1:0];
        b_nxt   = {b_r[WIDTH-2:0], 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          stat_nxt      = STAT_SOLVED;
          sol_nxt       = mul_pick[WIDTH-1:0];
          out_valid_nxt = 1'b1;
          state_nxt     = S_OUT;
        end
      end
      S_OUT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    n_r    <= n_nxt;
    r0_r   <= r0_nxt;
    r1_r   <= r1_nxt;
    t0_r   <= t0_nxt;
    t1_r   <= t1_nxt;
    np_r   <= np_nxt;
    acc_r  <= acc_nxt;
    cnt_r  <= cnt_nxt;
    stat_r <= stat_nxt;
    sol_r  <= sol_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = sol_r;
  assign out_tuser  = stat_r;

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a result is pending");

  a_sol_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != STAT_SOLVED)) |-> (out_tdata == '0))
    else $error("nonzero solution on unsolved status");

  a_sol_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == STAT_SOLVED)) |-> (out_tdata < np_r))
    else $error("solution not reduced modulo n/g");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    drsp.done |-> ((state_r == S_RED_W) || (state_r == S_EUC_W) ||
                   (state_r == S_B_W) || (state_r == S_N_W)))
    else $error("divider finished outside a wait state");
`endif

endmodule

`default_nettype wire

// ----- sv/mlcs_div.sv -----
`default_nettype none

module mlcs_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mlcs_pkg::div_req_t req,
  output mlcs_pkg::div_rsp_t     rsp
);
  import mlcs_pkg::*;

  // restoring divider, one quotient bit per cycle; also accumulates quot*mult (Horner)
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [WIDTH-1:0]     quo_r, quo_nxt;
  logic [WIDTH-1:0]     rem_r, rem_nxt;
  logic [WIDTH-1:0]     div_r, div_nxt;
  logic signed [TW-1:0] mul_r, mul_nxt;
  logic signed [PW-1:0] prod_r, prod_nxt;

  logic [WIDTH:0]       rem_sh;
  logic [WIDTH:0]       rem_sub;
  logic                 ge;

  always_comb begin
    rem_sh   = {rem_r, quo_r[WIDTH-1]};
    rem_sub  = rem_sh - {1'b0, div_r};
    ge       = (rem_sh >= {1'b0, div_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    mul_nxt  = mul_r;
    prod_nxt = prod_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(WIDTH - 1);
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      div_nxt  = req.divisor;
      mul_nxt  = req.mult;
      prod_nxt = '0;
    end else if (busy_r) begin
      rem_nxt  = ge ? rem_sub[WIDTH-1:0] : rem_sh[WIDTH-1:0];
      quo_nxt  = {quo_r[WIDTH-2:0], ge};
      prod_nxt = $signed({prod_r[PW-2:0], 1'b0}) + (ge ? PW'(mul_r) : PW'(0));
      cnt_nxt  = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    mul_r  <= mul_nxt;
    prod_r <= prod_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;
  assign rsp.prod = prod_r;

endmodule

`default_nettype wire
